// ===== src/cesc_pkg.sv =====
// Package for the clock edge setup constraint block.
// Field widths, request types, error codes and divider interface types.
// No dependencies.
package cesc_pkg;

  localparam int TIME_BITS = 20;
  localparam longint unsigned MAX_WINDOW = 64'd16777215;
  localparam int WIN_BITS = $clog2(MAX_WINDOW + 64'd1);
  localparam int LIMIT_BITS = 24;
  localparam logic [LIMIT_BITS-1:0] LIMIT_MAX = '1;

  // edge times reach offset + window + period
  localparam int EDGE_BITS = ((TIME_BITS > WIN_BITS) ? TIME_BITS : WIN_BITS) + 2;
  localparam int PROD_BITS = 2 * TIME_BITS;
  localparam int DIV_BITS = TIME_BITS + 1;

  localparam logic [1:0] ERR_OK     = 2'd0;
  localparam logic [1:0] ERR_ZERO   = 2'd1;
  localparam logic [1:0] ERR_WINDOW = 2'd2;
  localparam logic [1:0] ERR_NOGAP  = 2'd3;

  typedef struct packed {
    logic [TIME_BITS-1:0] launch_period;
    logic [TIME_BITS-1:0] launch_offset;
    logic [TIME_BITS-1:0] capture_period;
    logic [TIME_BITS-1:0] capture_offset;
  } in_item_t;

  typedef struct packed {
    logic [LIMIT_BITS-1:0] setup_limit;
    logic                  same_domain;
    logic [1:0]            error_code;
  } out_item_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_BITS-1:0]  dividend;
    logic [TIME_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_BITS-1:0]  quot;
    logic [TIME_BITS-1:0] rem;
  } div_rsp_t;

endpackage

// ===== src/cesc_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by the sequencer.
// Depends on cesc_pkg (widths, div_req_t, div_rsp_t).
module cesc_div import cesc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_BITS = $clog2(DIV_BITS + 1);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [CNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic [DIV_BITS-1:0]  quo_r, quo_nxt;
  logic [TIME_BITS-1:0] rem_r, rem_nxt;
  logic [TIME_BITS-1:0] dvs_r, dvs_nxt;
  logic [TIME_BITS:0]   trial;
  logic [TIME_BITS:0]   diff;
  logic                 ge;

  assign trial = {rem_r, quo_r[DIV_BITS-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = (trial >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (busy_r) begin
      rem_nxt = ge ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
      quo_nxt = {quo_r[DIV_BITS-2:0], ge};
      cnt_nxt = cnt_r - CNT_BITS'(1);
      if (cnt_r == CNT_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (req.start) begin
      busy_nxt = 1'b1;
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      cnt_nxt  = CNT_BITS'(DIV_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
  assign rsp.rem  = rem_r;

endmodule

// ===== src/clock_edge_setup_constraint.sv =====
// Setup constraint sequencer over one shared divider (cesc_pkg, cesc_div).
// A zero period or matching clocks give a result without the divider; otherwise the
// divider runs the Euclid steps for the gcd, then the edge count and the residues,
// and the sequencer then walks min(launch edges, capture edges) edges.
// One request at a time; in_ready is high only when idle.
// Reset: synchronous active-low rst_n clears sequencer and output valid.
module clock_edge_setup_constraint import cesc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  // Sequencer states
  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_CLASS = 13'b0000000000010,  // zero period / same domain check
    S_GCD   = 13'b0000000000100,  // Euclid step issue
    S_GWAIT = 13'b0000000001000,
    S_CWAIT = 13'b0000000010000,  // min period / gcd
    S_MUL   = 13'b0000000100000,  // window = max period * count
    S_CHK   = 13'b0000001000000,
    S_PREP  = 13'b0000010000000,  // residues modulo the short period
    S_PWAIT = 13'b0000100000000,
    S_INIT  = 13'b0001000000000,
    S_LOOP  = 13'b0010000000000,  // one edge per cycle
    S_FIN   = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_t;

  // residue divisions, in issue order
  localparam logic [1:0] PREP_STEP = 2'd0;
  localparam logic [1:0] PREP_P    = 2'd1;
  localparam logic [1:0] PREP_Q    = 2'd2;

  function automatic logic [LIMIT_BITS-1:0] sat_limit(input logic [EDGE_BITS-1:0] x);
    if (64'(x) > 64'(LIMIT_MAX)) sat_limit = LIMIT_MAX;
    else sat_limit = LIMIT_BITS'(x);
  endfunction

  state_t state_r, state_nxt;

  logic [TIME_BITS-1:0]  lp_r, lp_nxt, lo_r, lo_nxt, cp_r, cp_nxt, co_r, co_nxt;
  logic                  same_r, same_nxt;
  logic                  mode_a_r, mode_a_nxt;  // walk launch edges (cp <= lp)
  logic [TIME_BITS-1:0]  a_r, a_nxt, b_r, b_nxt;
  logic [TIME_BITS-1:0]  q_r, q_nxt;
  logic [PROD_BITS-1:0]  prod_r, prod_nxt;
  logic [TIME_BITS-1:0]  stepm_r, stepm_nxt, pm_r, pm_nxt, qm_r, qm_nxt;
  logic [TIME_BITS-1:0]  r_r, r_nxt;
  logic [EDGE_BITS-1:0]  v_r, v_nxt, lim_r, lim_nxt, last_r, last_nxt;
  logic [EDGE_BITS-1:0]  best_r, best_nxt;
  logic                  found_r, found_nxt;
  logic [TIME_BITS-1:0]  cnt_r, cnt_nxt;
  logic [1:0]            pidx_r, pidx_nxt;
  logic [LIMIT_BITS-1:0] res_limit_r, res_limit_nxt;
  logic [1:0]            res_err_r, res_err_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;

  div_req_t              div_req;
  div_rsp_t              div_rsp;

  // short period is the modulus, long period the walking step
  logic [TIME_BITS-1:0]  per_small, per_big;
  logic [EDGE_BITS-1:0]  win_e, lo_e, co_e, lp_e;
  logic [TIME_BITS:0]    r_sum, r_wrap, init_wrap;
  logic [EDGE_BITS-1:0]  cand;
  logic                  cand_ok;

  assign per_small = mode_a_r ? cp_r : lp_r;
  assign per_big   = mode_a_r ? lp_r : cp_r;
  assign win_e     = EDGE_BITS'(prod_r);
  assign lo_e      = EDGE_BITS'(lo_r);
  assign co_e      = EDGE_BITS'(co_r);
  assign lp_e      = EDGE_BITS'(lp_r);

  // residue advance by one long-period step
  assign r_sum     = {1'b0, r_r} + {1'b0, stepm_r};
  assign r_wrap    = r_sum - {1'b0, per_small};
  assign init_wrap = {1'b0, pm_r} + {1'b0, per_small} - {1'b0, qm_r};

  // gap for the current edge
  always_comb begin
    cand    = '0;
    cand_ok = 1'b0;
    if (mode_a_r) begin
      // launch edge v: next capture edge after it
      if (v_r < co_e) begin
        cand    = co_e - v_r;
        cand_ok = 1'b1;
      end else if (v_r < lim_r) begin
        cand    = EDGE_BITS'(per_small) - EDGE_BITS'(r_r);
        cand_ok = 1'b1;
      end
    end else begin
      // capture edge v: latest launch edge before it, clamped to the last one
      if (v_r > lo_e) begin
        cand_ok = 1'b1;
        if (v_r > lim_r) cand = v_r - last_r;
        else cand = EDGE_BITS'(r_r) + EDGE_BITS'(1);
      end
    end
  end

  // divider issue
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = DIV_BITS'(a_r);
    div_req.divisor  = b_r;
    if (state_r == S_GCD) begin
      div_req.start = 1'b1;
      if (b_r == '0) begin
        div_req.dividend = DIV_BITS'(per_small);
        div_req.divisor  = a_r;
      end
    end else if (state_r == S_PREP) begin
      div_req.start   = 1'b1;
      div_req.divisor = per_small;
      case (pidx_r)
        PREP_STEP: div_req.dividend = DIV_BITS'(per_big);
        PREP_P:    div_req.dividend = DIV_BITS'(mode_a_r ? lo_r : co_r);
        PREP_Q:    div_req.dividend = mode_a_r ? DIV_BITS'(co_r)
                                               : DIV_BITS'(lo_r) + DIV_BITS'(1);
        default:   div_req.dividend = DIV_BITS'(per_big);
      endcase
    end
  end

  cesc_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    state_nxt     = state_r;
    lp_nxt        = lp_r;
    lo_nxt        = lo_r;
    cp_nxt        = cp_r;
    co_nxt        = co_r;
    same_nxt      = same_r;
    mode_a_nxt    = mode_a_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    q_nxt         = q_r;
    prod_nxt      = prod_r;
    stepm_nxt     = stepm_r;
    pm_nxt        = pm_r;
    qm_nxt        = qm_r;
    r_nxt         = r_r;
    v_nxt         = v_r;
    lim_nxt       = lim_r;
    last_nxt      = last_r;
    best_nxt      = best_r;
    found_nxt     = found_r;
    cnt_nxt       = cnt_r;
    pidx_nxt      = pidx_r;
    res_limit_nxt = res_limit_r;
    res_err_nxt   = res_err_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          lp_nxt    = in_data.launch_period;
          lo_nxt    = in_data.launch_offset;
          cp_nxt    = in_data.capture_period;
          co_nxt    = in_data.capture_offset;
          same_nxt  = (in_data.launch_period == in_data.capture_period) &&
                      (in_data.launch_offset == in_data.capture_offset);
          state_nxt = S_CLASS;
        end
      end
      S_CLASS: begin
        if (lp_r == '0 || cp_r == '0) begin
          res_err_nxt   = ERR_ZERO;
          res_limit_nxt = LIMIT_MAX;
          state_nxt     = S_DONE;
        end else if (same_r) begin
          res_err_nxt   = ERR_OK;
          res_limit_nxt = sat_limit(lp_e);
          state_nxt     = S_DONE;
        end else begin
          a_nxt      = lp_r;
          b_nxt      = cp_r;
          mode_a_nxt = (cp_r <= lp_r);
          state_nxt  = S_GCD;
        end
      end
      S_GCD: begin
        // b == 0: a holds the gcd, divider now runs short period / gcd
        state_nxt = (b_r == '0) ? S_CWAIT : S_GWAIT;
      end
      S_GWAIT: begin
        if (div_rsp.done) begin
          a_nxt     = b_r;
          b_nxt     = div_rsp.rem;
          state_nxt = S_GCD;
        end
      end
      S_CWAIT: begin
        if (div_rsp.done) begin
          q_nxt     = TIME_BITS'(div_rsp.quot);
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt  = PROD_BITS'(per_big) * PROD_BITS'(q_r);
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (64'(prod_r) > MAX_WINDOW) begin
          res_err_nxt   = ERR_WINDOW;
          res_limit_nxt = LIMIT_MAX;
          state_nxt     = S_DONE;
        end else begin
          last_nxt  = lo_e + win_e;
          lim_nxt   = mode_a_r ? (co_e + win_e) : (lo_e + win_e + lp_e);
          v_nxt     = mode_a_r ? lo_e : co_e;
          cnt_nxt   = q_r;
          found_nxt = 1'b0;
          best_nxt  = '0;
          pidx_nxt  = PREP_STEP;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        state_nxt = S_PWAIT;
      end
      S_PWAIT: begin
        if (div_rsp.done) begin
          case (pidx_r)
            PREP_STEP: stepm_nxt = div_rsp.rem;
            PREP_P:    pm_nxt    = div_rsp.rem;
            PREP_Q:    qm_nxt    = div_rsp.rem;
            default:   stepm_nxt = div_rsp.rem;
          endcase
          if (pidx_r == PREP_Q) begin
            state_nxt = S_INIT;
          end else begin
            pidx_nxt  = pidx_r + 2'd1;
            state_nxt = S_PREP;
          end
        end
      end
      S_INIT: begin
        // (P - Q) mod short period, non-negative
        r_nxt     = (pm_r >= qm_r) ? (pm_r - qm_r) : TIME_BITS'(init_wrap);
        state_nxt = S_LOOP;
      end
      S_LOOP: begin
        if (cand_ok && (!found_r || cand < best_r)) begin
          best_nxt  = cand;
          found_nxt = 1'b1;
        end
        v_nxt = v_r + EDGE_BITS'(per_big);
        r_nxt = (r_sum >= {1'b0, per_small}) ? TIME_BITS'(r_wrap) : TIME_BITS'(r_sum);
        if (cnt_r == '0) state_nxt = S_FIN;
        else cnt_nxt = cnt_r - TIME_BITS'(1);
      end
      S_FIN: begin
        if (found_r) begin
          res_err_nxt   = ERR_OK;
          res_limit_nxt = sat_limit(best_r);
        end else begin
          res_err_nxt   = ERR_NOGAP;
          res_limit_nxt = LIMIT_MAX;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // output register frees as soon as the previous result is taken
        if (!out_valid_r || out_ready) begin
          out_data_nxt.setup_limit = res_limit_r;
          out_data_nxt.same_domain = same_r;
          out_data_nxt.error_code  = res_err_r;
          out_valid_nxt            = 1'b1;
          state_nxt                = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lp_r        <= lp_nxt;
    lo_r        <= lo_nxt;
    cp_r        <= cp_nxt;
    co_r        <= co_nxt;
    same_r      <= same_nxt;
    mode_a_r    <= mode_a_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    q_r         <= q_nxt;
    prod_r      <= prod_nxt;
    stepm_r     <= stepm_nxt;
    pm_r        <= pm_nxt;
    qm_r        <= qm_nxt;
    r_r         <= r_nxt;
    v_r         <= v_nxt;
    lim_r       <= lim_nxt;
    last_r      <= last_nxt;
    best_r      <= best_nxt;
    found_r     <= found_nxt;
    cnt_r       <= cnt_nxt;
    pidx_r      <= pidx_nxt;
    res_limit_r <= res_limit_nxt;
    res_err_r   <= res_err_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== test/setup_limit_checker.sv =====
// Checker for the clock edge setup constraint block: predicts each result
// from the accepted request and compares it with what the block returns.
// Depends on cesc_pkg for the request and result types and error codes.
module setup_limit_checker
  import cesc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        fail_count,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  out_item_t expected_limits[$];
  int        issued;
  int        returned;

  initial begin
    fail_count = 0;
    issued     = 0;
    returned   = 0;
  end

  assign pending = issued - returned;

  // Smallest positive capture-minus-launch edge gap over one lcm window.
  function automatic out_item_t predict_setup(input in_item_t req);
    longint unsigned lp, lo, cp, co;
    longint unsigned a, b, t, win, ns, nc;
    longint unsigned k, e, s, j, i, d, best;
    bit              found;
    out_item_t       res;
    lp = req.launch_period;
    lo = req.launch_offset;
    cp = req.capture_period;
    co = req.capture_offset;
    best  = 0;
    found = 1'b0;
    res.setup_limit = LIMIT_MAX;
    res.error_code  = ERR_OK;
    res.same_domain = (lp == cp) && (lo == co);
    if (lp == 0 || cp == 0) begin
      res.error_code = ERR_ZERO;
    end else if (res.same_domain) begin
      best  = lp;
      found = 1'b1;
    end else begin
      a = lp;
      b = cp;
      while (b != 0) begin
        t = a % b;
        a = b;
        b = t;
      end
      win = (lp / a) * cp;
      if (win > MAX_WINDOW) begin
        res.error_code = ERR_WINDOW;
      end else begin
        ns = win / lp + 1;
        nc = win / cp + 1;
        // walk whichever clock has fewer edges
        if (ns <= nc) begin
          for (k = 0; k < ns; k++) begin
            e = lo + k * lp;
            j = (e < co) ? 0 : (e - co) / cp + 1;
            if (j < nc) begin
              d = co + j * cp - e;
              if (!found || d < best) begin
                best  = d;
                found = 1'b1;
              end
            end
          end
        end else begin
          for (k = 0; k < nc; k++) begin
            s = co + k * cp;
            if (s > lo) begin
              i = (s - lo - 1) / lp;
              if (i > ns - 1) i = ns - 1;
              d = s - (lo + i * lp);
              if (!found || d < best) begin
                best  = d;
                found = 1'b1;
              end
            end
          end
        end
        if (!found) res.error_code = ERR_NOGAP;
      end
    end
    if (found) res.setup_limit = (best > LIMIT_MAX) ? LIMIT_MAX : best[LIMIT_BITS-1:0];
    return res;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    int        bad;
    bad = 0;
    if (rst_n) begin
      // retire before admitting, so a stray result cannot match a new request
      if (out_valid && out_ready) begin
        if (expected_limits.size() == 0) begin
          $display("%0t: result with no request pending, actual %p", $time, out_data);
          bad++;
        end else begin
          want = expected_limits.pop_front();
          if (out_data.setup_limit !== want.setup_limit) begin
            $display("%0t: setup_limit expected %0d actual %0d",
                     $time, want.setup_limit, out_data.setup_limit);
            bad++;
          end
          if (out_data.same_domain !== want.same_domain) begin
            $display("%0t: same_domain expected %0d actual %0d",
                     $time, want.same_domain, out_data.same_domain);
            bad++;
          end
          if (out_data.error_code !== want.error_code) begin
            $display("%0t: error_code expected %0d actual %0d",
                     $time, want.error_code, out_data.error_code);
            bad++;
          end
          returned <= returned + 1;
        end
      end
      if (in_valid && in_ready) begin
        expected_limits.push_back(predict_setup(in_data));
        issued <= issued + 1;
      end
      if (bad != 0) fail_count <= fail_count + bad;
    end
  end

endmodule

// ===== test/clock_edge_setup_constraint_test.sv =====
// Top of the testbench for the clock edge setup constraint block: drives
// requests, paces the result side and reports the verdict.
// Depends on cesc_pkg, clock_edge_setup_constraint and setup_limit_checker.
module clock_edge_setup_constraint_test;
  timeunit 1ns;
  timeprecision 1ps;
  import cesc_pkg::*;

  localparam int unsigned TIME_MAX        = (1 << TIME_BITS) - 1;
  localparam int unsigned WINDOW_LIMIT    = 32'(MAX_WINDOW);
  localparam int          RANDOM_REQUESTS = 121;
  // longer than the slowest single request, so the block backs up on its input
  localparam int          HOLDOFF_CYCLES  = 6000;
  localparam int          DRAIN_CYCLES    = 32;
  localparam int          CYCLE_LIMIT     = 5000000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  int fail_count;
  int pending;
  int requests_sent;
  int cycle_count;
  bit holdoff_done;

  clock_edge_setup_constraint DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  setup_limit_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Idle length: mostly none or short, now and then a long one.
  function automatic int unsigned idle_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 93) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  // Random clock pair. Most are built as g*a, g*b so the lcm window stays
  // within the limit and the edge walk actually runs, some with no later edge;
  // the rest cover zero periods, matching clocks and raw 20-bit values.
  function automatic in_item_t random_clocks();
    in_item_t    r;
    int unsigned kind, a, b, g, g_top, hi;
    kind = $urandom_range(0, 99);
    r.launch_period  = TIME_BITS'($urandom_range(0, TIME_MAX));
    r.launch_offset  = TIME_BITS'($urandom_range(0, TIME_MAX));
    r.capture_period = TIME_BITS'($urandom_range(0, TIME_MAX));
    r.capture_offset = TIME_BITS'($urandom_range(0, TIME_MAX));
    if (kind < 8) begin
      case ($urandom_range(0, 2))
        0: r.launch_period = '0;
        1: r.capture_period = '0;
        default: begin
          r.launch_period  = '0;
          r.capture_period = '0;
        end
      endcase
    end else if (kind < 16) begin
      // same clock on both sides
      if ($urandom_range(0, 1) != 0) r.launch_period = TIME_BITS'($urandom_range(1, 5000));
      r.capture_period = r.launch_period;
      r.capture_offset = r.launch_offset;
    end else if (kind >= 24) begin
      if (kind >= 32 && $urandom_range(0, 19) == 0) begin
        // many edges: long walk, window close to the limit
        a = $urandom_range(1, 4096);
        b = $urandom_range(1, 4096);
      end else begin
        a = $urandom_range(1, 24);
        b = $urandom_range(1, 24);
      end
      if (kind >= 32 && kind < 36) b = a;
      hi    = (a > b) ? a : b;
      g_top = TIME_MAX / hi;
      if (kind < 32 && g_top > 100) g_top = 100;
      if (a * b > 576 && g_top > WINDOW_LIMIT / (a * b)) g_top = WINDOW_LIMIT / (a * b);
      g = $urandom_range(1, g_top);
      r.launch_period  = TIME_BITS'(g * a);
      r.capture_period = TIME_BITS'(g * b);
      if (kind < 32) begin
        // every capture edge at or before the first launch edge
        r.capture_offset = TIME_BITS'($urandom_range(0, 1000));
        r.launch_offset  = TIME_BITS'(r.capture_offset + g * a * b + $urandom_range(0, 1000));
      end else if ($urandom_range(0, 1) != 0) begin
        r.launch_offset  = TIME_BITS'($urandom_range(0, g * hi));
        r.capture_offset = TIME_BITS'($urandom_range(0, g * hi));
      end
    end
    return r;
  endfunction

  // Present one request and hold it until accepted; optional idle after.
  task automatic offer_request(input in_item_t req, input bit no_idle);
    int unsigned gap;
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    requests_sent++;
    gap = no_idle ? 0 : idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic offer_clocks(input int unsigned lp, input int unsigned lo,
                              input int unsigned cp, input int unsigned co);
    in_item_t r;
    r.launch_period  = TIME_BITS'(lp);
    r.launch_offset  = TIME_BITS'(lo);
    r.capture_period = TIME_BITS'(cp);
    r.capture_offset = TIME_BITS'(co);
    offer_request(r, 1'b0);
  endtask

  // Sender pauses until every outstanding result is back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Result side: runs of ready and gaps; one long hold-off early in the
  // random part while the sender keeps offering, so in_ready has to drop.
  initial begin : result_pacing
    int unsigned gap;
    int          n;
    out_ready    <= 1'b0;
    holdoff_done = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!holdoff_done && requests_sent >= 40) begin
        holdoff_done = 1'b1;
        out_ready <= 1'b0;
        for (n = 0; n < HOLDOFF_CYCLES; n++) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      // no stalls while the sender runs back to back
      gap = (requests_sent >= 118 && requests_sent < 138) ? 0 : idle_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int n;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_data       <= '0;
    requests_sent = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero periods, with and without matching clocks
    offer_clocks(0, 0, 0, 0);
    offer_clocks(0, 5, 1000, 5);
    offer_clocks(1000, 0, 0, 0);
    offer_clocks(TIME_MAX, 0, 0, 0);
    // matching clocks, smallest offset and all-ones fields
    offer_clocks(1000, 0, 1000, 0);
    offer_clocks(TIME_MAX, TIME_MAX, TIME_MAX, TIME_MAX);
    // window too long; window exactly at the limit (4095 * 4097); just over
    offer_clocks(TIME_MAX, 0, TIME_MAX - 1, TIME_MAX);
    offer_clocks(4095, 0, 4097, 7);
    offer_clocks(4096, 3, 4097, 0);
    // no capture edge after any launch edge
    offer_clocks(1, 1000, 2, 0);
    offer_clocks(TIME_MAX, TIME_MAX, 1, 0);
    // ordinary pairs, both walk directions, shared factors
    offer_clocks(10, 0, 15, 3);
    offer_clocks(7, 100, 3, 0);
    offer_clocks(3, 0, 7, 100);
    offer_clocks(2, 0, 4, 1);
    // equal periods with different offsets, including the widest spread
    offer_clocks(1, 0, 1, 1);
    offer_clocks(5, 0, 5, TIME_MAX);
    // extreme offsets and a capture clock with a million edges in the window
    offer_clocks(1, TIME_MAX, 2, TIME_MAX);
    offer_clocks(TIME_MAX, 0, 1, TIME_MAX);
    wait_for_results();

    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == RANDOM_REQUESTS / 2) wait_for_results();
      offer_request(random_clocks(), (n >= 100 && n < 120));
    end
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
